// ===== hdl/rmfw_pkg.sv =====
// ----------------------------------------------------------------------------
// rmfw_pkg
// Types and status codes shared by the recursive mutex with its FIFO of
// waiting threads.
// ----------------------------------------------------------------------------
package rmfw_pkg;

  typedef enum logic [3:0] {
    STATUS_ACQUIRED        = 4'd0,
    STATUS_REENTERED       = 4'd1,
    STATUS_QUEUED          = 4'd2,
    STATUS_PARTLY_RELEASED = 4'd3,
    STATUS_FREED           = 4'd4,
    STATUS_HANDED_OFF      = 4'd5,
    STATUS_NOT_HOLDER      = 4'd6,
    STATUS_ALREADY_WAITING = 4'd7,
    STATUS_QUEUE_FULL      = 4'd8,
    STATUS_DEPTH_OVERFLOW  = 4'd9
  } status_e;

  typedef enum logic [1:0] {
    STATE_CLEAR,
    STATE_IDLE,
    STATE_EXEC
  } state_e;

  localparam logic MODE_ACQUIRE = 1'b0;
  localparam logic MODE_RELEASE = 1'b1;

  // Lock state seen by the decision logic.
  typedef struct packed {
    logic rel_req;
    logic held;
    logic is_owner;
    logic waiting;
    logic depth_max;
    logic depth_gt1;
    logic queue_full;
    logic queue_empty;
  } view_t;

  // Decision for one transaction.
  typedef struct packed {
    status_e status;
    logic    grant;
    logic    reenter;
    logic    enqueue;
    logic    dec;
    logic    handoff;
    logic    free;
  } action_t;

endpackage

// ===== hdl/rmfw_ram.sv =====
// ----------------------------------------------------------------------------
// rmfw_ram
// Generic single-write, single-read synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module rmfw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/rmfw_decide.sv =====
// ----------------------------------------------------------------------------
// rmfw_decide
// Decides the outcome of one acquire or release transaction from the
// current lock state.
// ----------------------------------------------------------------------------
module rmfw_decide (
  input  rmfw_pkg::view_t   view_i,
  output rmfw_pkg::action_t act_o
);
  import rmfw_pkg::*;

  always_comb begin
    act_o = '{status: STATUS_NOT_HOLDER, default: 1'b0};
    if (!view_i.rel_req) begin
      priority if (view_i.held && view_i.is_owner) begin
        if (view_i.depth_max) begin
          act_o.status = STATUS_DEPTH_OVERFLOW;
        end else begin
          act_o.status  = STATUS_REENTERED;
          act_o.reenter = 1'b1;
        end
      end else if (view_i.waiting) begin
        act_o.status = STATUS_ALREADY_WAITING;
      end else if (!view_i.held) begin
        act_o.status = STATUS_ACQUIRED;
        act_o.grant  = 1'b1;
      end else if (view_i.queue_full) begin
        act_o.status = STATUS_QUEUE_FULL;
      end else begin
        act_o.status  = STATUS_QUEUED;
        act_o.enqueue = 1'b1;
      end
    end else begin
      priority if (!view_i.held || !view_i.is_owner) begin
        act_o.status = STATUS_NOT_HOLDER;
      end else if (view_i.depth_gt1) begin
        act_o.status = STATUS_PARTLY_RELEASED;
        act_o.dec    = 1'b1;
      end else if (!view_i.queue_empty) begin
        act_o.status  = STATUS_HANDED_OFF;
        act_o.handoff = 1'b1;
      end else begin
        act_o.status = STATUS_FREED;
        act_o.free   = 1'b1;
      end
    end
  end

endmodule

// ===== hdl/recursive_mutex_fifo_waiters_unit.sv =====
// ----------------------------------------------------------------------------
// recursive_mutex_fifo_waiters_unit
// Recursive mutex with a FIFO of waiting threads, a waiting flag per thread
// and direct hand-off to the oldest waiter on the final release.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake               Payload
//  request   in         in_valid_i, in_stall_o  mode_i, thread_id_i
//  result    out        out_valid_o, out_stall_i status_o, wake_valid_o,
//                                               wake_thread_o, held_o,
//                                               holder_thread_o, hold_depth_o
//
// Each transaction is accepted in the IDLE state, where the accept reads the
// waiting flag and the queue head from their RAMs, and is decided and written
// back in the EXEC state. After reset every entry of the waiting flag RAM is
// swept to zero, and no request is accepted during the sweep. A stalled result
// holds the write-back cycle; a new request is still accepted while a finished
// result waits.
// ----------------------------------------------------------------------------
module recursive_mutex_fifo_waiters_unit #(
  parameter int THREAD_ID_BITS = 8,
  parameter int QUEUE_DEPTH    = 16,
  parameter int DEPTH_BITS     = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       mode_i,
  input  logic [7:0] thread_id_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [3:0] status_o,
  output logic       wake_valid_o,
  output logic [7:0] wake_thread_o,
  output logic       held_o,
  output logic [7:0] holder_thread_o,
  output logic [7:0] hold_depth_o
);
  import rmfw_pkg::*;

  localparam int TW = THREAD_ID_BITS;
  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int DW = DEPTH_BITS;
  localparam int NT = 1 << THREAD_ID_BITS;

  state_e state_q, state_d;

  logic [TW-1:0]   clr_q, clr_d;
  logic            mode_q;
  logic [TW-1:0]   tid_q;
  logic            held_q, held_d;
  logic [TW-1:0]   owner_q, owner_d;
  logic [DW-1:0]   nest_q, nest_d;
  logic [PW-1:0]   head_q, head_d;
  logic [PW-1:0]   tail_q, tail_d;
  logic [CW-1:0]   count_q, count_d;

  logic            out_valid_q, out_valid_d;
  status_e         status_q;
  logic            wake_valid_q;
  logic [TW-1:0]   wake_thread_q;
  logic            out_held_q;
  logic [TW-1:0]   out_holder_q;
  logic [DW-1:0]   out_depth_q;

  logic            accept;
  logic            commit;
  logic            clearing;
  logic [TW+7:0]   tid_ext;
  logic [TW-1:0]   tid_in;
  logic [TW-1:0]   woken;
  logic            mark_rdata;
  logic            mark_we;
  logic [TW-1:0]   mark_waddr;
  logic            mark_wdata;
  logic            queue_we;
  view_t           view;
  action_t         act;
  logic [TW+7:0]   wake_ext;
  logic [TW+7:0]   holder_ext;
  logic [DW+7:0]   depth_ext;

  assign tid_ext = {{TW{1'b0}}, thread_id_i};
  assign tid_in  = tid_ext[TW-1:0];

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      STATE_CLEAR: begin
        if (clr_q == {TW{1'b1}}) begin
          state_d = STATE_IDLE;
        end
      end
      STATE_IDLE: begin
        if (in_valid_i) begin
          state_d = STATE_EXEC;
        end
      end
      STATE_EXEC: begin
        if (!out_valid_q || !out_stall_i) begin
          state_d = STATE_IDLE;
        end
      end
      default: state_d = STATE_CLEAR;
    endcase
  end

  always_comb begin
    in_stall_o = 1'b1;
    commit     = 1'b0;
    clearing   = 1'b0;
    unique case (state_q)
      STATE_CLEAR: clearing = 1'b1;
      STATE_IDLE:  in_stall_o = 1'b0;
      STATE_EXEC:  commit = !out_valid_q || !out_stall_i;
      default:     clearing = 1'b0;
    endcase
  end

  assign accept = in_valid_i && !in_stall_o;
  assign clr_d  = clearing ? clr_q + TW'(1) : clr_q;

  rmfw_ram #(
    .WIDTH (1),
    .DEPTH (NT)
  ) u_mark_ram (
    .clk_i   (clk_i),
    .we_i    (mark_we),
    .waddr_i (mark_waddr),
    .wdata_i (mark_wdata),
    .re_i    (accept),
    .raddr_i (tid_in),
    .rdata_o (mark_rdata)
  );

  rmfw_ram #(
    .WIDTH (TW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue_ram (
    .clk_i   (clk_i),
    .we_i    (queue_we),
    .waddr_i (tail_q),
    .wdata_i (tid_q),
    .re_i    (accept),
    .raddr_i (head_q),
    .rdata_o (woken)
  );

  assign view.rel_req     = (mode_q == MODE_RELEASE);
  assign view.held        = held_q;
  assign view.is_owner    = (owner_q == tid_q);
  assign view.waiting     = mark_rdata;
  assign view.depth_max   = (nest_q == {DW{1'b1}});
  assign view.depth_gt1   = (nest_q > DW'(1));
  assign view.queue_full  = (count_q >= CW'(QUEUE_DEPTH));
  assign view.queue_empty = (count_q == '0);

  rmfw_decide u_decide (
    .view_i (view),
    .act_o  (act)
  );

  always_comb begin
    mark_we    = 1'b0;
    mark_waddr = clr_q;
    mark_wdata = 1'b0;
    if (clearing) begin
      mark_we = 1'b1;
    end else if (commit && act.enqueue) begin
      mark_we    = 1'b1;
      mark_waddr = tid_q;
      mark_wdata = 1'b1;
    end else if (commit && act.handoff) begin
      mark_we    = 1'b1;
      mark_waddr = woken;
    end
  end

  assign queue_we = commit && act.enqueue;

  always_comb begin
    held_d  = held_q;
    owner_d = owner_q;
    nest_d  = nest_q;
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    if (commit) begin
      if (act.grant) begin
        held_d  = 1'b1;
        owner_d = tid_q;
        nest_d  = DW'(1);
      end
      if (act.reenter) begin
        nest_d = nest_q + DW'(1);
      end
      if (act.dec) begin
        nest_d = nest_q - DW'(1);
      end
      if (act.enqueue) begin
        tail_d  = (tail_q == PW'(QUEUE_DEPTH - 1)) ? '0 : tail_q + PW'(1);
        count_d = count_q + CW'(1);
      end
      if (act.handoff) begin
        owner_d = woken;
        nest_d  = DW'(1);
        head_d  = (head_q == PW'(QUEUE_DEPTH - 1)) ? '0 : head_q + PW'(1);
        count_d = count_q - CW'(1);
      end
      if (act.free) begin
        held_d  = 1'b0;
        owner_d = '0;
        nest_d  = '0;
      end
    end
  end

  assign out_valid_d = commit || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= STATE_CLEAR;
      clr_q       <= '0;
      held_q      <= 1'b0;
      owner_q     <= '0;
      nest_q      <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      held_q      <= held_d;
      owner_q     <= owner_d;
      nest_q      <= nest_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q <= mode_i;
      tid_q  <= tid_in;
    end
    if (commit) begin
      status_q      <= act.status;
      wake_valid_q  <= act.handoff;
      wake_thread_q <= act.handoff ? woken : '0;
      out_held_q    <= held_d;
      out_holder_q  <= held_d ? owner_d : '0;
      out_depth_q   <= held_d ? nest_d : '0;
    end
  end

  assign wake_ext   = {8'd0, wake_thread_q};
  assign holder_ext = {8'd0, out_holder_q};
  assign depth_ext  = {8'd0, out_depth_q};

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign wake_valid_o    = wake_valid_q;
  assign wake_thread_o   = wake_ext[7:0];
  assign held_o          = out_held_q;
  assign holder_thread_o = holder_ext[7:0];
  assign hold_depth_o    = depth_ext[7:0];

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(QUEUE_DEPTH))
    else $error("Waiter count exceeds the queue depth.");

  a_free_is_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !held_q |-> (owner_q == '0) && (nest_q == '0))
    else $error("Free lock keeps an owner or a depth.");

  a_handoff_owner : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && wake_valid_o) |-> held_o && (holder_thread_o == wake_thread_o))
    else $error("Woken thread is not the new holder.");

  a_no_accept_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == STATE_CLEAR) |-> in_stall_o && !commit)
    else $error("Request taken during the clearing sweep.");

endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for recursive_mutex_fifo_waiters_unit. A table of
// directed requests covers grant, re-entry, depth overflow, queueing, a full
// queue, refusals and hand-off. Random episodes follow, each with its own
// pool of contending threads. Each result is checked against its typed
// table row or a built-in lock predictor. The sender works in bursts and
// the receiver stalls on a pattern of its own, with one long hold-off.
// ----------------------------------------------------------------------------
module testbench;

  import rmfw_pkg::*;

  localparam int THREAD_ID_BITS = 8;
  localparam int QUEUE_DEPTH    = 16;
  localparam int DEPTH_BITS     = 8;
  localparam logic [7:0] TID_MASK = 8'((1 << THREAD_ID_BITS) - 1);
  localparam int NEST_LIMIT     = (1 << DEPTH_BITS) - 1;
  localparam int RANDOM_ITEMS   = 450;
  localparam int CYCLE_LIMIT    = 200000;
  localparam int DIRECTED_COUNT = 24;

  typedef struct packed {
    status_e    status;
    logic       wake_valid;
    logic [7:0] wake_thread;
    logic       held;
    logic [7:0] holder_thread;
    logic [7:0] hold_depth;
  } lock_result_t;

  typedef struct packed {
    logic         mode;
    logic [7:0]   tid;
    logic [8:0]   count;
    logic         stride;
    logic         typed;
    lock_result_t result;
  } directed_row_t;

  localparam directed_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
    '{MODE_ACQUIRE, 8'd0,   9'd1,   1'b0, 1'b1,
      '{STATUS_ACQUIRED,        1'b0, 8'd0, 1'b1, 8'd0,   8'd1}},
    '{MODE_RELEASE, 8'd0,   9'd1,   1'b0, 1'b1,
      '{STATUS_FREED,           1'b0, 8'd0, 1'b0, 8'd0,   8'd0}},
    '{MODE_RELEASE, 8'd255, 9'd1,   1'b0, 1'b1,
      '{STATUS_NOT_HOLDER,      1'b0, 8'd0, 1'b0, 8'd0,   8'd0}},
    '{MODE_ACQUIRE, 8'd255, 9'd1,   1'b0, 1'b1,
      '{STATUS_ACQUIRED,        1'b0, 8'd0, 1'b1, 8'd255, 8'd1}},
    '{MODE_ACQUIRE, 8'd255, 9'd1,   1'b0, 1'b1,
      '{STATUS_REENTERED,       1'b0, 8'd0, 1'b1, 8'd255, 8'd2}},
    '{MODE_ACQUIRE, 8'd255, 9'd253, 1'b0, 1'b0, '0},
    '{MODE_ACQUIRE, 8'd255, 9'd1,   1'b0, 1'b1,
      '{STATUS_DEPTH_OVERFLOW,  1'b0, 8'd0, 1'b1, 8'd255, 8'd255}},
    '{MODE_RELEASE, 8'd255, 9'd253, 1'b0, 1'b0, '0},
    '{MODE_ACQUIRE, 8'd0,   9'd1,   1'b0, 1'b1,
      '{STATUS_QUEUED,          1'b0, 8'd0, 1'b1, 8'd255, 8'd2}},
    '{MODE_ACQUIRE, 8'd0,   9'd1,   1'b0, 1'b1,
      '{STATUS_ALREADY_WAITING, 1'b0, 8'd0, 1'b1, 8'd255, 8'd2}},
    '{MODE_ACQUIRE, 8'd1,   9'd15,  1'b1, 1'b0, '0},
    '{MODE_ACQUIRE, 8'd128, 9'd1,   1'b0, 1'b1,
      '{STATUS_QUEUE_FULL,      1'b0, 8'd0, 1'b1, 8'd255, 8'd2}},
    '{MODE_RELEASE, 8'd7,   9'd1,   1'b0, 1'b1,
      '{STATUS_NOT_HOLDER,      1'b0, 8'd0, 1'b1, 8'd255, 8'd2}},
    '{MODE_RELEASE, 8'd255, 9'd1,   1'b0, 1'b1,
      '{STATUS_PARTLY_RELEASED, 1'b0, 8'd0, 1'b1, 8'd255, 8'd1}},
    '{MODE_RELEASE, 8'd255, 9'd1,   1'b0, 1'b1,
      '{STATUS_HANDED_OFF,      1'b1, 8'd0, 1'b1, 8'd0,   8'd1}},
    '{MODE_ACQUIRE, 8'd0,   9'd1,   1'b0, 1'b1,
      '{STATUS_REENTERED,       1'b0, 8'd0, 1'b1, 8'd0,   8'd2}},
    '{MODE_ACQUIRE, 8'd255, 9'd1,   1'b0, 1'b1,
      '{STATUS_QUEUED,          1'b0, 8'd0, 1'b1, 8'd0,   8'd2}},
    '{MODE_RELEASE, 8'd0,   9'd2,   1'b0, 1'b0, '0},
    '{MODE_RELEASE, 8'd1,   9'd15,  1'b1, 1'b0, '0},
    '{MODE_RELEASE, 8'd255, 9'd1,   1'b0, 1'b1,
      '{STATUS_FREED,           1'b0, 8'd0, 1'b0, 8'd0,   8'd0}},
    '{MODE_ACQUIRE, 8'd170, 9'd1,   1'b0, 1'b0, '0},
    '{MODE_ACQUIRE, 8'd85,  9'd1,   1'b0, 1'b0, '0},
    '{MODE_RELEASE, 8'd170, 9'd1,   1'b0, 1'b0, '0},
    '{MODE_RELEASE, 8'd85,  9'd1,   1'b0, 1'b0, '0}
  };

  logic       clk_i;
  logic       rst_ni        = 1'b0;
  logic       in_valid      = 1'b0;
  logic       in_stall;
  logic       mode          = MODE_ACQUIRE;
  logic [7:0] thread_id     = 8'd0;
  logic       out_valid;
  logic       out_stall     = 1'b0;
  logic [3:0] status;
  logic       wake_valid;
  logic [7:0] wake_thread;
  logic       held;
  logic [7:0] holder_thread;
  logic [7:0] hold_depth;

  // Predicted lock state.
  logic       lock_taken    = 1'b0;
  logic [7:0] lock_owner    = 8'd0;
  int         lock_nesting  = 0;
  logic [7:0] waiter_fifo [$];
  bit         waiter_flag [256];

  lock_result_t pending_results [$];
  int           failure_count   = 0;
  int           cycle_count     = 0;
  int           burst_left      = 0;
  bit           holdoff_due     = 1'b0;

  recursive_mutex_fifo_waiters_unit #(
    .THREAD_ID_BITS(THREAD_ID_BITS),
    .QUEUE_DEPTH   (QUEUE_DEPTH),
    .DEPTH_BITS    (DEPTH_BITS)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .mode_i         (mode),
    .thread_id_i    (thread_id),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .status_o       (status),
    .wake_valid_o   (wake_valid),
    .wake_thread_o  (wake_thread),
    .held_o         (held),
    .holder_thread_o(holder_thread),
    .hold_depth_o   (hold_depth)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic lock_result_t predict_lock_step(logic req_mode, logic [7:0] raw_tid);
    lock_result_t outcome;
    logic [7:0]   tid;
    logic [7:0]   woken;
    tid     = raw_tid & TID_MASK;
    outcome = '0;
    if (req_mode == MODE_ACQUIRE) begin
      if (lock_taken && lock_owner == tid) begin
        if (lock_nesting >= NEST_LIMIT) begin
          outcome.status = STATUS_DEPTH_OVERFLOW;
        end else begin
          lock_nesting++;
          outcome.status = STATUS_REENTERED;
        end
      end else if (waiter_flag[tid]) begin
        outcome.status = STATUS_ALREADY_WAITING;
      end else if (!lock_taken) begin
        lock_taken     = 1'b1;
        lock_owner     = tid;
        lock_nesting   = 1;
        outcome.status = STATUS_ACQUIRED;
      end else if (waiter_fifo.size() >= QUEUE_DEPTH) begin
        outcome.status = STATUS_QUEUE_FULL;
      end else begin
        waiter_fifo.push_back(tid);
        waiter_flag[tid] = 1'b1;
        outcome.status   = STATUS_QUEUED;
      end
    end else begin
      if (!lock_taken || lock_owner != tid) begin
        outcome.status = STATUS_NOT_HOLDER;
      end else if (lock_nesting > 1) begin
        lock_nesting--;
        outcome.status = STATUS_PARTLY_RELEASED;
      end else if (waiter_fifo.size() > 0) begin
        woken               = waiter_fifo.pop_front();
        waiter_flag[woken]  = 1'b0;
        lock_owner          = woken;
        lock_nesting        = 1;
        outcome.wake_valid  = 1'b1;
        outcome.wake_thread = woken;
        outcome.status      = STATUS_HANDED_OFF;
      end else begin
        lock_taken     = 1'b0;
        lock_owner     = 8'd0;
        lock_nesting   = 0;
        outcome.status = STATUS_FREED;
      end
    end
    outcome.held          = lock_taken;
    outcome.holder_thread = lock_taken ? lock_owner : 8'd0;
    outcome.hold_depth    = lock_taken ? 8'(lock_nesting) : 8'd0;
    return outcome;
  endfunction

  task automatic report_failure(string what, lock_result_t want, lock_result_t got);
    failure_count++;
    if (failure_count <= 10) begin
      $display("%s: expected status %0d wake %0b/%0d held %0b holder %0d depth %0d,",
               what, want.status, want.wake_valid, want.wake_thread, want.held,
               want.holder_thread, want.hold_depth);
      $display("  got status %0d wake %0b/%0d held %0b holder %0d depth %0d",
               got.status, got.wake_valid, got.wake_thread, got.held,
               got.holder_thread, got.hold_depth);
    end
  endtask

  task automatic send_request(logic req_mode, logic [7:0] tid, logic typed,
                              lock_result_t typed_result);
    lock_result_t predicted;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 120)
                                               : $urandom_range(1, 25);
    end
    burst_left--;
    in_valid  <= 1'b1;
    mode      <= req_mode;
    thread_id <= tid;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    predicted = predict_lock_step(req_mode, tid);
    pending_results.push_back(typed ? typed_result : predicted);
  endtask

  always @(posedge clk_i) begin : result_monitor
    lock_result_t want;
    lock_result_t got;
    if (rst_ni && out_valid && !out_stall) begin
      got = '{status_e'(status), wake_valid, wake_thread, held, holder_thread,
              hold_depth};
      if (pending_results.size() == 0) begin
        report_failure("unexpected result", '0, got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) report_failure("mismatch", want, got);
      end
    end
  end

  initial begin : result_stall
    int phase_len;
    int phase_kind;
    int stall_pct;
    bit holdoff_done;
    holdoff_done = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (holdoff_due && !holdoff_done) begin
        holdoff_done = 1'b1;
        out_stall <= 1'b1;
        repeat (150) @(posedge clk_i);
      end
      phase_kind = $urandom_range(0, 3);
      phase_len  = $urandom_range(10, 60);
      stall_pct  = $urandom_range(10, 80);
      for (int c = 0; c < phase_len; c++) begin
        case (phase_kind)
          0: begin
            out_stall <= 1'b0;
          end
          1: begin
            out_stall <= ($urandom_range(0, 99) < stall_pct);
          end
          2: begin
            out_stall <= c[0];
          end
          default: begin
            out_stall <= (c % 7 < 3);
          end
        endcase
        @(posedge clk_i);
      end
    end
  end

  initial begin : stimulus
    directed_row_t row;
    logic [7:0]    thread_pool [24];
    int            pool_size;
    int            episode_left;
    int            pick;
    logic          req_mode;
    logic [7:0]    tid;
    for (int k = 0; k < 256; k++) waiter_flag[k] = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < DIRECTED_COUNT; r++) begin
      row = DIRECTED_ROWS[r];
      for (int k = 0; k < row.count; k++) begin
        send_request(row.mode, row.tid + (row.stride ? 8'(k) : 8'd0), row.typed,
                     row.result);
      end
    end

    holdoff_due  = 1'b1;
    pool_size    = 2;
    episode_left = 0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (episode_left == 0) begin
        episode_left = $urandom_range(20, 60);
        pool_size    = $urandom_range(2, 24);
        for (int p = 0; p < pool_size; p++) thread_pool[p] = 8'($urandom_range(0, 255));
      end
      episode_left--;
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        req_mode = 1'($urandom_range(0, 1));
        tid      = 8'($urandom_range(0, 255));
      end else if (pick < 55 && lock_taken) begin
        req_mode = MODE_RELEASE;
        tid      = lock_owner;
      end else if (pick < 63) begin
        req_mode = MODE_RELEASE;
        tid      = thread_pool[$urandom_range(0, pool_size - 1)];
      end else begin
        req_mode = MODE_ACQUIRE;
        tid      = thread_pool[$urandom_range(0, pool_size - 1)];
      end
      send_request(req_mode, tid, 1'b0, '0);
    end
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    while (pending_results.size() != 0) begin
      report_failure("missing result", pending_results.pop_front(), '0);
    end
    if (failure_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
